// ===== src/mcls_pkg.sv =====
package mcls_pkg;

   localparam int MAX_CLUSTERS   = 16;
   localparam int MAX_POSITIONS  = 256;
   localparam int MAX_CATEGORIES = 32;

   localparam int CL_W       = $clog2(MAX_CLUSTERS);
   localparam int POS_W      = $clog2(MAX_POSITIONS);
   localparam int CAT_W      = $clog2(MAX_CATEGORIES);
   localparam int BANK_DEPTH = MAX_POSITIONS * MAX_CATEGORIES;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   // fixed field widths
   localparam int CLUSTER_W  = 4;
   localparam int POSITION_W = 8;
   localparam int CATEGORY_W = 5;
   localparam int ENTRY_W    = 32;
   localparam int SYM_W      = 8;
   localparam int SUM_W      = 40;
   localparam int SEQN_W     = 16;
   localparam int NCLUS_W    = 5;
   localparam int NCAT_W     = 6;
   localparam int SLEN_W     = 9;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 9;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 64;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

   typedef enum logic [CSR_AW-1:0] {
      CSR_NUM_CLUSTERS   = 2'd0,
      CSR_NUM_CATEGORIES = 2'd1,
      CSR_SEQ_LENGTH     = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_SCORE = 1'b1
   } op_type;

   typedef struct packed {
      logic [NCLUS_W-1:0] num_clusters;
      logic [NCAT_W-1:0]  num_categories;
      logic [SLEN_W-1:0]  seq_length;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [CL_W-1:0]     cluster;
      logic                wr_ok;
      logic [BANK_AW-1:0]  addr;
      logic [ENTRY_W-1:0]  value;
      logic                sym_bad;
      logic                seq_end;
      logic                seq_bad;
      logic [SEQN_W-1:0]   seq_num;
   } cmd_type;

   typedef struct packed {
      logic [MAX_CLUSTERS-1:0][SUM_W-1:0] sums;
      logic [NCLUS_W-1:0]                 count;
      logic [SEQN_W-1:0]                  seq_num;
      logic                               bad;
   } snap_type;

   function automatic logic [BANK_AW-1:0] bank_addr(input logic [POS_W-1:0] pos,
                                                    input logic [CAT_W-1:0] cat);
      return BANK_AW'(BANK_AW'(pos) * BANK_AW'(MAX_CATEGORIES) + BANK_AW'(cat));
   endfunction

endpackage

// ===== src/mcls_ram.sv =====
module mcls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/mcls_front.sv =====
module mcls_front
   import mcls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [CSR_DW-1:0]     csr_data,
   output cfg_type               cfg,
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_ready
);

   logic [CLUSTER_W-1:0]  f_cluster;
   logic [POSITION_W-1:0] f_position;
   logic [CATEGORY_W-1:0] f_category;
   logic [ENTRY_W-1:0]    f_value;
   logic [SYM_W-1:0]      f_symbol;
   op_type                f_op;
   logic                  accept;
   logic                  sym_bad;
   logic                  seq_end;

   cfg_type               cfg_ff;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [SEQN_W-1:0]     seqn_ff, seqn_in;
   logic                  bad_seen_ff, bad_seen_in;

   logic [NCLUS_W-1:0]    nclus_wr;
   logic [NCAT_W-1:0]     ncat_wr;
   logic [SLEN_W-1:0]     slen_wr;

   assign f_cluster  = req_tdata[3:0];
   assign f_position = req_tdata[11:4];
   assign f_category = req_tdata[16:12];
   assign f_value    = req_tdata[48:17];
   assign f_symbol   = req_tdata[56:49];
   assign f_op       = op_type'(req_tuser);

   assign req_tready = cmd_ready;
   assign accept     = req_tvalid && cmd_ready;
   assign csr_ready  = 1'b1;
   assign cfg        = cfg_ff;

   // clamp register writes into their legal ranges
   always_comb begin
      nclus_wr = csr_data[NCLUS_W-1:0];
      if (nclus_wr == '0) begin
         nclus_wr = NCLUS_W'(1);
      end else if (32'(nclus_wr) > MAX_CLUSTERS) begin
         nclus_wr = NCLUS_W'(MAX_CLUSTERS);
      end
      ncat_wr = csr_data[NCAT_W-1:0];
      if (ncat_wr == '0) begin
         ncat_wr = NCAT_W'(1);
      end else if (32'(ncat_wr) > MAX_CATEGORIES) begin
         ncat_wr = NCAT_W'(MAX_CATEGORIES);
      end
      slen_wr = csr_data[SLEN_W-1:0];
      if (slen_wr == '0) begin
         slen_wr = SLEN_W'(1);
      end else if (32'(slen_wr) > MAX_POSITIONS) begin
         slen_wr = SLEN_W'(MAX_POSITIONS);
      end
   end

   assign sym_bad = 32'(f_symbol) >= 32'(cfg_ff.num_categories);
   assign seq_end = (32'(pos_ff) + 1) >= 32'(cfg_ff.seq_length);

   always_comb begin
      cmd         = '0;
      cmd.op      = f_op;
      cmd.cluster = CL_W'(f_cluster);
      cmd.value   = f_value;
      cmd.wr_ok   = (32'(f_cluster) < MAX_CLUSTERS) && (32'(f_position) < MAX_POSITIONS)
                    && (32'(f_category) < MAX_CATEGORIES);
      cmd.sym_bad = sym_bad;
      cmd.seq_end = seq_end;
      cmd.seq_bad = bad_seen_ff || sym_bad;
      cmd.seq_num = seqn_ff;
      if (f_op == OP_WRITE) begin
         cmd.addr = bank_addr(POS_W'(f_position), CAT_W'(f_category));
      end else begin
         cmd.addr = bank_addr(pos_ff, CAT_W'(f_symbol));
      end
   end

   assign cmd_valid = req_tvalid;

   always_comb begin
      pos_in      = pos_ff;
      seqn_in     = seqn_ff;
      bad_seen_in = bad_seen_ff;
      if (accept && f_op == OP_SCORE) begin
         if (seq_end) begin
            pos_in      = '0;
            seqn_in     = seqn_ff + SEQN_W'(1);
            bad_seen_in = 1'b0;
         end else begin
            pos_in      = pos_ff + POS_W'(1);
            bad_seen_in = bad_seen_ff || sym_bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_clusters   <= NCLUS_W'(MAX_CLUSTERS);
         cfg_ff.num_categories <= NCAT_W'(MAX_CATEGORIES);
         cfg_ff.seq_length     <= SLEN_W'(MAX_POSITIONS);
         pos_ff                <= '0;
         seqn_ff               <= '0;
         bad_seen_ff           <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         seqn_ff     <= seqn_in;
         bad_seen_ff <= bad_seen_in;
         if (csr_valid) begin
            unique case (csr_index_type'(csr_addr))
               CSR_NUM_CLUSTERS:   cfg_ff.num_clusters   <= nclus_wr;
               CSR_NUM_CATEGORIES: cfg_ff.num_categories <= ncat_wr;
               CSR_SEQ_LENGTH:     cfg_ff.seq_length     <= slen_wr;
               default:            cfg_ff                <= cfg_ff;
            endcase
         end
      end
   end

endmodule

// ===== src/mcls_fifo.sv =====
module mcls_fifo
   import mcls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    in_ready,
   input  logic    pop,
   output cmd_type head,
   output logic    head_valid
);

   cmd_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_PW:0]     count_ff;
   logic                 do_push, do_pop;

   assign in_ready   = count_ff != (FIFO_PW+1)'(FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && in_ready;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PW'(1);
         end
         count_ff <= count_ff + (FIFO_PW+1)'(do_push) - (FIFO_PW+1)'(do_pop);
      end
   end

endmodule

// ===== src/mcls_back.sv =====
module mcls_back
   import mcls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     head_valid,
   input  cmd_type  head,
   output logic     pop,
   input  logic     drain_free,
   output logic     snap_load,
   output snap_type snap
);

   logic                  head_end;
   logic [ENTRY_W-1:0]    rdata [MAX_CLUSTERS];
   logic [SUM_W-1:0]      total [MAX_CLUSTERS];

   logic                  s2_valid_ff;
   logic                  s2_sym_bad_ff;
   logic                  s2_end_ff;
   logic                  s2_seq_bad_ff;
   logic [SEQN_W-1:0]     s2_seq_num_ff;
   logic [SUM_W-1:0]      sums_ff [MAX_CLUSTERS];

   assign head_end = head.op == OP_SCORE && head.seq_end;
   // hold an end-of-sequence symbol until the result buffer can take it
   assign pop = head_valid && (!head_end || (drain_free && !(s2_valid_ff && s2_end_ff)));

   for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_bank
      mcls_ram #(
         .WIDTH (ENTRY_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock (clock),
         .we    (pop && head.op == OP_WRITE && head.wr_ok && head.cluster == CL_W'(c)),
         .waddr (head.addr),
         .wdata (head.value),
         .raddr (head.addr),
         .rdata (rdata[c])
      );
   end

   always_comb begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
         if (!s2_sym_bad_ff && c < 32'(cfg.num_clusters)) begin
            total[c] = sums_ff[c] +
                       {{(SUM_W-ENTRY_W){rdata[c][ENTRY_W-1]}}, rdata[c]};
         end else begin
            total[c] = sums_ff[c];
         end
      end
   end

   assign snap_load = s2_valid_ff && s2_end_ff;

   always_comb begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
         snap.sums[c] = total[c];
      end
      snap.count   = cfg.num_clusters;
      snap.seq_num = s2_seq_num_ff;
      snap.bad     = s2_seq_bad_ff;
   end

   always_ff @(posedge clock) begin
      s2_sym_bad_ff <= head.sym_bad;
      s2_end_ff     <= head.seq_end;
      s2_seq_bad_ff <= head.seq_bad;
      s2_seq_num_ff <= head.seq_num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         for (int c = 0; c < MAX_CLUSTERS; c++) begin
            sums_ff[c] <= '0;
         end
      end else begin
         s2_valid_ff <= pop && head.op == OP_SCORE;
         if (s2_valid_ff) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
               sums_ff[c] <= s2_end_ff ? '0 : total[c];
            end
         end
      end
   end

endmodule

// ===== src/mcls_drain.sv =====
module mcls_drain
   import mcls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  snap_load,
   input  snap_type              snap,
   output logic                  drain_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [SUM_W-1:0]     snap_ff [MAX_CLUSTERS];
   logic [SEQN_W-1:0]    seqn_ff;
   logic                 bad_ff;
   logic [NCLUS_W-1:0]   left_ff;
   logic [CL_W-1:0]      idx_ff;
   logic                 advance;

   logic                 out_valid_ff;
   logic [CLUSTER_W-1:0] out_idx_ff;
   logic [SUM_W-1:0]     out_score_ff;
   logic [SEQN_W-1:0]    out_seqn_ff;
   logic                 out_bad_ff;
   logic                 out_last_ff;

   assign drain_free = left_ff == '0;
   assign advance    = left_ff != '0 && (!out_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (snap_load) begin
         for (int c = 0; c < MAX_CLUSTERS; c++) begin
            snap_ff[c] <= snap.sums[c];
         end
         seqn_ff <= snap.seq_num;
         bad_ff  <= snap.bad;
      end
      if (advance) begin
         out_idx_ff   <= CLUSTER_W'(idx_ff);
         out_score_ff <= snap_ff[idx_ff];
         out_seqn_ff  <= seqn_ff;
         out_bad_ff   <= bad_ff;
         out_last_ff  <= left_ff == NCLUS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (snap_load) begin
            left_ff <= snap.count;
            idx_ff  <= '0;
         end else if (advance) begin
            left_ff <= left_ff - NCLUS_W'(1);
            idx_ff  <= idx_ff + CL_W'(1);
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CLUSTER_W-SUM_W-SEQN_W){1'b0}},
                        out_seqn_ff, out_score_ff, out_idx_ff};
   assign rsp_tuser  = out_bad_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== src/mixture_cluster_log_score.sv =====
// Scores fixed-length symbol sequences against each cluster in use of a mixture model.
// req channel: one item per handshake. tuser = op; op 0 writes one Q16.16 table
//   entry at (cluster, position, category), op 1 streams the next sequence symbol.
// rsp channel: after seq_length symbols, one item per cluster in use, in cluster
//   order, with tlast on the highest cluster and tuser = bad_symbol for the sequence.
// csr channel: write num_clusters (0), num_categories (1), seq_length (2); values are
//   clamped to their legal ranges. Write only while the block is idle.
// Throughput: one req item per cycle while the queue has room, table writes and symbols
//   alike, as each cluster owns a table bank read in parallel with the others. Results
//   leave at one per cycle while the receiver is ready; a sequence that ends before the
//   result side is free holds its last symbol at the queue head until the side is free.
// After its last symbol is taken, the first result of a sequence passes the queue and
//   bank read, accumulation into the result buffer and the result register.
// A four-deep queue parts the accepting front from the accumulating back; a result
//   buffer holds one finished sequence while the next one accumulates, so a stalled
//   receiver only holds the input once that buffer and the queue are full.
// Reset clears sums, counters and registers to their defaults; table contents are
//   undefined until written and must be loaded before use.
module mixture_cluster_log_score
   import mcls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cluster[3:0], position[11:4], category[16:12], entry_value[48:17], symbol[56:49]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cluster_index[3:0], score[43:4], sequence_number[59:44]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // bad_symbol
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [CSR_DW-1:0]     csr_data
);

   cfg_type  cfg;
   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_ready;
   logic     head_valid;
   cmd_type  head;
   logic     pop;
   logic     drain_free;
   logic     snap_load;
   snap_type snap;

   // classify items, track position and sequence number, hold the registers
   mcls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready)
   );

   // decouple the front from the back
   mcls_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_valid),
      .push_data  (cmd),
      .in_ready   (cmd_ready),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // table banks and per-cluster accumulators
   mcls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .drain_free (drain_free),
      .snap_load  (snap_load),
      .snap       (snap)
   );

   // hand out finished scores one cluster per item
   mcls_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .snap_load  (snap_load),
      .snap       (snap),
      .drain_free (drain_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
